FILE: src/bcgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_pkg: shared types and constants of the button gesture detector
// Item structs, configuration struct, register and event codes.
// ----------------------------------------------------------------------------
package bcgd_pkg;

   localparam int NUM_KEYS   = 8;
   localparam int MASK_W     = 8;
   localparam int KEY_W      = 3;
   localparam int SCAN_KEYS  = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;
   localparam int CSR_ADDR_W = 5;
   localparam int QDEPTH     = 4;
   localparam int QCOUNT_W   = 3;

   typedef enum logic [2:0] {
      REG_ACTIVE_HIGH       = 3'd0,
      REG_DEBOUNCE_MS       = 3'd1,
      REG_CLICK_MS          = 3'd2,
      REG_LONG_PRESS_MS     = 3'd3,
      REG_KEY_ENABLE_MASK   = 3'd4,
      REG_DOUBLE_CLICK_MASK = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      EV_CLICK  = 3'd0,
      EV_DOUBLE = 3'd1,
      EV_LSTART = 3'd2,
      EV_LDUR   = 3'd3,
      EV_LSTOP  = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [31:0]       now_ms;
      logic [MASK_W-1:0] key_levels;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       event_kind;
      logic [KEY_W-1:0] key_index;
      logic [31:0]      elapsed_ms;
      logic             last_event;
   } rsp_item_type;

   typedef struct packed {
      logic              active_high;
      logic [31:0]       debounce_ms;
      logic [31:0]       click_ms;
      logic [31:0]       long_press_ms;
      logic [MASK_W-1:0] key_enable_mask;
      logic [MASK_W-1:0] double_click_mask;
   } cfg_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } ev_pair_type;

endpackage

FILE: src/bcgd_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_csr: configuration registers
// Register file behind the bus port; a timing register write restarts the
// gesture machine.
// ----------------------------------------------------------------------------
module bcgd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bcgd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output bcgd_pkg::cfg_type                   cfg,
   output logic                                cfg_clear
);
   import bcgd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (wr_en) begin
         unique case (idx)
            REG_ACTIVE_HIGH: begin
               cfg_in.active_high = pwdata[0];
               cfg_clear = 1'b1;
            end
            REG_DEBOUNCE_MS: begin
               cfg_in.debounce_ms = pwdata;
               cfg_clear = 1'b1;
            end
            REG_CLICK_MS: begin
               cfg_in.click_ms = pwdata;
               cfg_clear = 1'b1;
            end
            REG_LONG_PRESS_MS: begin
               cfg_in.long_press_ms = pwdata;
               cfg_clear = 1'b1;
            end
            REG_KEY_ENABLE_MASK:   cfg_in.key_enable_mask   = pwdata[MASK_W-1:0];
            REG_DOUBLE_CLICK_MASK: cfg_in.double_click_mask = pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ACTIVE_HIGH:       prdata = {31'd0, cfg_ff.active_high};
         REG_DEBOUNCE_MS:       prdata = cfg_ff.debounce_ms;
         REG_CLICK_MS:          prdata = cfg_ff.click_ms;
         REG_LONG_PRESS_MS:     prdata = cfg_ff.long_press_ms;
         REG_KEY_ENABLE_MASK:   prdata = {24'd0, cfg_ff.key_enable_mask};
         REG_DOUBLE_CLICK_MASK: prdata = {24'd0, cfg_ff.double_click_mask};
         default:               prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high       <= 1'b0;
         cfg_ff.debounce_ms       <= 32'd20;
         cfg_ff.click_ms          <= 32'd600;
         cfg_ff.long_press_ms     <= 32'd1000;
         cfg_ff.key_enable_mask   <= '0;
         cfg_ff.double_click_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_on_timing_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (idx == REG_DEBOUNCE_MS || idx == REG_CLICK_MS ||
                 idx == REG_LONG_PRESS_MS || idx == REG_ACTIVE_HIGH)) |-> cfg_clear)
      else $error("timing register write did not restart the machine");
   a_no_clear_on_mask_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (idx == REG_KEY_ENABLE_MASK || idx == REG_DOUBLE_CLICK_MASK))
      |-> !cfg_clear)
      else $error("mask write restarted the machine");
   a_cfg_holds_without_write: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write");
`endif

endmodule
`default_nettype wire

FILE: src/bcgd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_core: key pick and gesture state machine
// Registers one poll item, picks the pressed key and runs the click,
// double-click and long-press machine, producing up to two events.
// ----------------------------------------------------------------------------
module bcgd_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bcgd_pkg::req_item_type req_item,
   input  wire bcgd_pkg::cfg_type      cfg,
   input  wire logic                   cfg_clear,
   input  wire logic                   room,
   output bcgd_pkg::ev_pair_type       push
);
   import bcgd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DOWN   = 3'd1,
      ST_UP     = 3'd2,
      ST_SECOND = 3'd3,
      ST_LONG   = 3'd4
   } state_type;

   state_type         state_ff, state_in;
   logic              in_valid_ff, in_valid_in;
   req_item_type      in_item_ff;
   logic [31:0]       press_ff, press_in;
   logic [31:0]       release_ff, release_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   logic              accept;
   logic              fire;
   logic [MASK_W-1:0] pressed_bits;
   logic [MASK_W-1:0] dc_bits;
   logic              pressed;
   logic [KEY_W-1:0]  key_pick;
   logic [31:0]       since_press;
   logic [31:0]       since_release;
   logic              wants;
   ev_pair_type       ev;

   function automatic rsp_item_type make_event(event_kind_type kind, logic [KEY_W-1:0] key,
                                               logic [31:0] ms, logic last);
      rsp_item_type e;
      e.event_kind = kind;
      e.key_index  = key;
      e.elapsed_ms = ms;
      e.last_event = last;
      return e;
   endfunction

   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign fire      = in_valid_ff && room;

   assign pressed_bits = (cfg.active_high ? in_item_ff.key_levels : ~in_item_ff.key_levels)
                         & cfg.key_enable_mask;
   assign dc_bits      = cfg.key_enable_mask & cfg.double_click_mask;

   always_comb begin
      pressed  = 1'b0;
      key_pick = '0;
      for (int i = SCAN_KEYS - 1; i >= 0; i--) begin
         if (pressed_bits[i]) begin
            pressed  = 1'b1;
            key_pick = KEY_W'(i);
         end
      end
   end

   assign key_in        = (fire && pressed) ? key_pick : key_ff;
   assign since_press   = in_item_ff.now_ms - press_ff;
   assign since_release = in_item_ff.now_ms - release_ff;
   assign wants         = dc_bits[key_in];

   always_comb begin
      state_in   = state_ff;
      press_in   = press_ff;
      release_in = release_ff;
      ev.count   = 2'd0;
      ev.first   = make_event(EV_CLICK, key_in, 32'd0, 1'b1);
      ev.second  = make_event(EV_CLICK, key_in, 32'd0, 1'b1);
      unique case (state_ff)
         ST_DOWN: begin
            if (!pressed && since_press < cfg.debounce_ms) begin
               state_in = ST_IDLE;
            end else if (!pressed) begin
               state_in   = ST_UP;
               release_in = in_item_ff.now_ms;
            end else if (since_press > cfg.long_press_ms) begin
               ev.count  = 2'd2;
               ev.first  = make_event(EV_LSTART, key_in, 32'd0, 1'b0);
               ev.second = make_event(EV_LDUR, key_in, since_press, 1'b1);
               state_in  = ST_LONG;
            end
         end
         ST_UP: begin
            if (!wants || since_press > cfg.click_ms) begin
               ev.count = 2'd1;
               ev.first = make_event(EV_CLICK, key_in, 32'd0, 1'b1);
               state_in = ST_IDLE;
            end else if (pressed && since_release > cfg.debounce_ms) begin
               state_in = ST_SECOND;
               press_in = in_item_ff.now_ms;
            end
         end
         ST_SECOND: begin
            if (!pressed && since_press > cfg.debounce_ms) begin
               ev.count = 2'd1;
               ev.first = make_event(EV_DOUBLE, key_in, 32'd0, 1'b1);
               state_in = ST_IDLE;
            end
         end
         ST_LONG: begin
            ev.count = 2'd1;
            if (!pressed) begin
               ev.first = make_event(EV_LSTOP, key_in, since_press, 1'b1);
               state_in = ST_IDLE;
            end else begin
               ev.first = make_event(EV_LDUR, key_in, since_press, 1'b1);
            end
         end
         default: begin
            if (pressed) begin
               state_in = ST_DOWN;
               press_in = in_item_ff.now_ms;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      push = ev;
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_valid_ff <= 1'b0;
         press_ff    <= '0;
         release_ff  <= '0;
         key_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         key_ff      <= key_in;
         if (cfg_clear) begin
            state_ff   <= ST_IDLE;
            press_ff   <= '0;
            release_ff <= '0;
         end else if (fire) begin
            state_ff   <= state_in;
            press_ff   <= press_in;
            release_ff <= release_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_clear_goes_idle: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> (state_ff == ST_IDLE && press_ff == 32'd0 && release_ff == 32'd0))
      else $error("configuration restart did not clear the machine");
   a_pair_enters_long: assert property (@(posedge clock) disable iff (reset)
      (fire && !cfg_clear && push.count == 2'd2) |=> state_ff == ST_LONG)
      else $error("two-event item did not enter long press");
   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!fire && !cfg_clear) |=> ($stable(state_ff) && $stable(press_ff)))
      else $error("machine moved without an item");
`endif

endmodule
`default_nettype wire

FILE: src/bcgd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_queue: result item queue
// Shifting queue that takes up to two events per cycle and presents the
// oldest one on the result channel.
// ----------------------------------------------------------------------------
module bcgd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bcgd_pkg::ev_pair_type push,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bcgd_pkg::rsp_item_type     rsp_item
);
   import bcgd_pkg::*;

   rsp_item_type            q_ff [QDEPTH];
   rsp_item_type            q_in [QDEPTH];
   logic [QCOUNT_W-1:0]     count_ff, count_in;
   logic [QCOUNT_W-1:0]     base;
   logic                    pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign base      = count_ff - QCOUNT_W'(pop);
   assign room      = (base <= QCOUNT_W'(QDEPTH - 2));
   assign count_in  = base + QCOUNT_W'(push.count);

   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push.count != 2'd0 && QCOUNT_W'(i) == base) begin
            q_in[i] = push.first;
         end
         if (push.count == 2'd2 && QCOUNT_W'(i) == base + QCOUNT_W'(1)) begin
            q_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_W'(QDEPTH))
      else $error("result queue overfilled");
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("events pushed without room");
   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("queue fill changed without push or pop");
`endif

endmodule
`default_nettype wire

FILE: src/button_click_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_gesture_detector: click, double click and long press events
// Polls key levels with a timestamp and reports gesture events per key.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_item (now_ms, key_levels)
//   rsp      out        rsp_valid/rsp_stall  rsp_item (event_kind, key_index,
//                                                      elapsed_ms, last_event)
//   csr      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One poll item is taken per cycle while the queue has room; it waits in the
// input register until its events fit, and the queue hands out one item per
// cycle while rsp_stall is low. A two-event item queues both events in order.
// The single input register and the four-entry result queue set the rate.
// Reset is synchronous and leaves the queue empty and the machine idle.
// A stalled result channel fills the queue and then stalls the poll channel.
// ----------------------------------------------------------------------------
module button_click_gesture_detector (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bcgd_pkg::req_item_type          req_item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bcgd_pkg::rsp_item_type               rsp_item,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [bcgd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import bcgd_pkg::*;

   cfg_type     cfg;
   logic        cfg_clear;
   logic        room;
   ev_pair_type push;

   bcgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg       (cfg),
      .cfg_clear (cfg_clear)
   );

   bcgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .room      (room),
      .push      (push)
   );

   bcgd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
